// ----- hdl/nmea_fx_pkg.sv -----
// shared types, character codes and subfield layout for the nmea field extractor
package nmea_fx_pkg;

    localparam int MAX_SENTENCE = 128;
    localparam int SENT_POS_W   = $clog2(MAX_SENTENCE + 1);

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    localparam logic [2:0] HDR_LEN        = 3'd6;
    localparam logic [3:0] COUNT_SAT      = 4'd15;
    localparam logic [3:0] TEXT_COUNT_MAX = 4'd8;
    localparam logic [3:0] FINAL_FIELD    = 4'd10;

    localparam logic KIND_RMC = 1'b0;
    localparam logic KIND_GGA = 1'b1;

    localparam logic [4:0] ITEM_HOUR     = 5'd0;
    localparam logic [4:0] ITEM_MIN      = 5'd1;
    localparam logic [4:0] ITEM_SEC      = 5'd2;
    localparam logic [4:0] ITEM_STATUS   = 5'd3;
    localparam logic [4:0] ITEM_LAT_DEG  = 5'd4;
    localparam logic [4:0] ITEM_LAT_MIN  = 5'd5;
    localparam logic [4:0] ITEM_LAT_HEMI = 5'd6;
    localparam logic [4:0] ITEM_LON_DEG  = 5'd7;
    localparam logic [4:0] ITEM_LON_MIN  = 5'd8;
    localparam logic [4:0] ITEM_LON_HEMI = 5'd9;
    localparam logic [4:0] ITEM_SPEED    = 5'd10;
    localparam logic [4:0] ITEM_DAY      = 5'd11;
    localparam logic [4:0] ITEM_MONTH    = 5'd12;
    localparam logic [4:0] ITEM_YEAR     = 5'd13;
    localparam logic [4:0] ITEM_SATS     = 5'd14;
    localparam logic [4:0] ITEM_HDOP     = 5'd15;
    localparam logic [4:0] ITEM_ALT      = 5'd16;
    localparam logic [4:0] ITEM_UNIT     = 5'd17;
    localparam logic [4:0] ITEM_END      = 5'd18;

    typedef struct packed {
        logic        sentence_kind;
        logic [4:0]  item_id;
        logic [63:0] text;
        logic [3:0]  text_len;
        logic        last;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] item_id;
        logic [3:0] end_pos;
    } sub_t;

    function automatic logic [7:0] hdr_rmc_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4D;
            3'd5:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hdr_gga_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h47;
            3'd5:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic sub_t make_sub(input logic [4:0] id, input logic [3:0] end_pos);
        sub_t s;
        s.hit     = 1'b1;
        s.item_id = id;
        s.end_pos = end_pos;
        return s;
    endfunction

    // subfield open at a given field and character position, by sentence kind
    function automatic sub_t sub_lookup(input logic kind, input logic [3:0] field,
                                        input logic [3:0] pos);
        sub_t s;
        s = '0;
        unique case (field)
            4'd1:
            begin
                if (pos < 4'd2)      s = make_sub(ITEM_HOUR, 4'd2);
                else if (pos < 4'd4) s = make_sub(ITEM_MIN, 4'd4);
                else if (pos < 4'd6) s = make_sub(ITEM_SEC, 4'd6);
            end
            4'd2:
            begin
                if (kind == KIND_RMC)
                begin
                    if (pos < 4'd1) s = make_sub(ITEM_STATUS, 4'd1);
                end
                else
                begin
                    if (pos < 4'd2)      s = make_sub(ITEM_LAT_DEG, 4'd2);
                    else if (pos < 4'd9) s = make_sub(ITEM_LAT_MIN, 4'd9);
                end
            end
            4'd3:
            begin
                if (kind == KIND_RMC)
                begin
                    if (pos < 4'd2)      s = make_sub(ITEM_LAT_DEG, 4'd2);
                    else if (pos < 4'd9) s = make_sub(ITEM_LAT_MIN, 4'd9);
                end
                else if (pos < 4'd1) s = make_sub(ITEM_LAT_HEMI, 4'd1);
            end
            4'd4:
            begin
                if (kind == KIND_RMC)
                begin
                    if (pos < 4'd1) s = make_sub(ITEM_LAT_HEMI, 4'd1);
                end
                else
                begin
                    if (pos < 4'd3)       s = make_sub(ITEM_LON_DEG, 4'd3);
                    else if (pos < 4'd10) s = make_sub(ITEM_LON_MIN, 4'd10);
                end
            end
            4'd5:
            begin
                if (kind == KIND_RMC)
                begin
                    if (pos < 4'd3)       s = make_sub(ITEM_LON_DEG, 4'd3);
                    else if (pos < 4'd10) s = make_sub(ITEM_LON_MIN, 4'd10);
                end
                else if (pos < 4'd1) s = make_sub(ITEM_LON_HEMI, 4'd1);
            end
            4'd6:
            begin
                if (kind == KIND_RMC && pos < 4'd1) s = make_sub(ITEM_LON_HEMI, 4'd1);
            end
            4'd7:
            begin
                if (kind == KIND_RMC)
                begin
                    if (pos < 4'd5) s = make_sub(ITEM_SPEED, 4'd5);
                end
                else if (pos < 4'd2) s = make_sub(ITEM_SATS, 4'd2);
            end
            4'd8:
            begin
                if (kind == KIND_GGA && pos < 4'd3) s = make_sub(ITEM_HDOP, 4'd3);
            end
            4'd9:
            begin
                if (kind == KIND_RMC)
                begin
                    if (pos < 4'd2)      s = make_sub(ITEM_DAY, 4'd2);
                    else if (pos < 4'd4) s = make_sub(ITEM_MONTH, 4'd4);
                    else if (pos < 4'd6) s = make_sub(ITEM_YEAR, 4'd6);
                end
                else if (pos < 4'd5) s = make_sub(ITEM_ALT, 4'd5);
            end
            4'd10:
            begin
                if (kind == KIND_GGA && pos < 4'd1) s = make_sub(ITEM_UNIT, 4'd1);
            end
            default:
            begin
                s = '0;
            end
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/nmea_rmc_gga_field_extractor.sv -----
// top level of the nmea rmc/gga field extractor
//
// channels:
//   input: one ascii character per transfer on byte_in, with in_valid and in_stall
//   output: one extracted subfield per transfer (sentence_kind, item_id, text,
//   text_len, last), with out_valid and out_stall; text holds the first character
//   in text[7:0], last marks the final result of a sentence, item 18 is a bare end
//   marker. a '$' opens a sentence; only $GPRMC and $GPGGA headers are parsed, other
//   sentences are skipped until the next '$'
// timing:
//   a transferred character waits in the input register and is parsed into the
//   result register when it is free, and its result (if any) is shown from there.
//   one character per cycle sustained while no result is held by out_stall
// reset:
//   rst_n clears both registers' valid flags and puts the parser outside any
//   sentence, waiting for '$'
// stall:
//   while a result waits under out_stall the parser holds; in_stall is high at once
//   if the input register holds a character, otherwise that register takes one more
//   character first. in_stall falls once the result is taken
module nmea_rmc_gga_field_extractor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        sentence_kind,
    output logic [4:0]  item_id,
    output logic [63:0] text,
    output logic [3:0]  text_len,
    output logic        last
);

    logic                  hold_valid;
    logic [7:0]            hold_byte;
    logic                  slot_free;
    logic                  step;
    logic                  res_valid;
    nmea_fx_pkg::result_t  res;
    nmea_fx_pkg::result_t  out_res;

    // parse the held character when the result register can take its outcome
    assign step = hold_valid && slot_free;

    nmea_fx_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_in    (byte_in),
        .advance    (step),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    nmea_fx_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_in   (hold_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    nmea_fx_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    // unpack the result register onto the payload ports
    assign sentence_kind = out_res.sentence_kind;
    assign item_id       = out_res.item_id;
    assign text          = out_res.text;
    assign text_len      = out_res.text_len;
    assign last          = out_res.last;

endmodule

// ----- hdl/nmea_fx_in_reg.sv -----
// input register stage holding one received character
module nmea_fx_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    input  logic       advance,
    output logic       hold_valid,
    output logic [7:0] hold_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            byte_reg <= byte_in;
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule

// ----- hdl/nmea_fx_parser.sv -----
// sentence state tracking and subfield capture, one character per step
module nmea_fx_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            byte_in,
    output logic                  res_valid,
    output nmea_fx_pkg::result_t  res
);

    logic                              in_sentence_reg, in_sentence_next;
    logic [2:0]                        header_pos_reg, header_pos_next;
    logic [1:0]                        kind_match_reg, kind_match_next;
    logic [nmea_fx_pkg::SENT_POS_W-1:0] sentence_pos_reg, sentence_pos_next;
    logic [3:0]                        comma_count_reg, comma_count_next;
    logic [3:0]                        field_pos_reg, field_pos_next;
    logic [63:0]                       text_buffer_reg, text_buffer_next;
    logic [3:0]                        text_count_reg, text_count_next;

    logic                kind;
    nmea_fx_pkg::sub_t   sub;
    logic [3:0]          cc_inc;
    logic [3:0]          fp_inc;
    logic [3:0]          cnt_cap;
    logic [63:0]         buf_cap;
    logic [1:0]          km_new;
    logic                ends;
    logic                at_limit;

    assign kind     = kind_match_reg[0] ? nmea_fx_pkg::KIND_RMC : nmea_fx_pkg::KIND_GGA;
    assign sub      = nmea_fx_pkg::sub_lookup(kind, comma_count_reg, field_pos_reg);
    assign cc_inc   = (comma_count_reg == nmea_fx_pkg::COUNT_SAT) ?
                      comma_count_reg : comma_count_reg + 4'd1;
    assign fp_inc   = (field_pos_reg == nmea_fx_pkg::COUNT_SAT) ?
                      field_pos_reg : field_pos_reg + 4'd1;
    assign cnt_cap  = (text_count_reg == nmea_fx_pkg::TEXT_COUNT_MAX) ?
                      text_count_reg : text_count_reg + 4'd1;
    assign km_new   = kind_match_reg &
                      {nmea_fx_pkg::hdr_gga_char(header_pos_reg) == byte_in,
                       nmea_fx_pkg::hdr_rmc_char(header_pos_reg) == byte_in};
    assign at_limit = sentence_pos_reg >=
                      nmea_fx_pkg::SENT_POS_W'(nmea_fx_pkg::MAX_SENTENCE);

    // drop the character into the next free byte lane
    always_comb
    begin
        buf_cap = text_buffer_reg;
        buf_cap[{text_count_reg[2:0], 3'b000} +: 8] =
            text_buffer_reg[{text_count_reg[2:0], 3'b000} +: 8] | byte_in;
    end

    always_comb
    begin
        in_sentence_next  = in_sentence_reg;
        header_pos_next   = header_pos_reg;
        kind_match_next   = kind_match_reg;
        sentence_pos_next = sentence_pos_reg;
        comma_count_next  = comma_count_reg;
        field_pos_next    = field_pos_reg;
        text_buffer_next  = text_buffer_reg;
        text_count_next   = text_count_reg;
        res_valid         = 1'b0;
        res               = '0;
        res.sentence_kind = kind;
        ends              = 1'b0;

        if (byte_in == nmea_fx_pkg::CHAR_DOLLAR)
        begin
            in_sentence_next  = 1'b1;
            header_pos_next   = 3'd1;
            kind_match_next   = 2'b11;
            sentence_pos_next = nmea_fx_pkg::SENT_POS_W'(1);
            comma_count_next  = 4'd0;
            field_pos_next    = 4'd0;
            text_buffer_next  = '0;
            text_count_next   = 4'd0;
        end
        else if (in_sentence_reg)
        begin
            if (header_pos_reg < nmea_fx_pkg::HDR_LEN)
            begin
                kind_match_next   = km_new;
                header_pos_next   = header_pos_reg + 3'd1;
                sentence_pos_next = sentence_pos_reg + nmea_fx_pkg::SENT_POS_W'(1);
                if (km_new == 2'b00)
                    in_sentence_next = 1'b0;
            end
            else if (at_limit || byte_in == nmea_fx_pkg::CHAR_LF)
            begin
                res_valid = 1'b1;
                res.last  = 1'b1;
                if (sub.hit)
                begin
                    res.item_id  = sub.item_id;
                    res.text     = text_buffer_reg;
                    res.text_len = text_count_reg;
                end
                else
                begin
                    res.item_id = nmea_fx_pkg::ITEM_END;
                end
                in_sentence_next = 1'b0;
                text_buffer_next = '0;
                text_count_next  = 4'd0;
            end
            else
            begin
                sentence_pos_next = sentence_pos_reg + nmea_fx_pkg::SENT_POS_W'(1);
                if (byte_in == nmea_fx_pkg::CHAR_COMMA)
                begin
                    comma_count_next = cc_inc;
                    ends = (cc_inc > nmea_fx_pkg::FINAL_FIELD) ||
                           (cc_inc == nmea_fx_pkg::FINAL_FIELD && kind == nmea_fx_pkg::KIND_RMC);
                    res.last = ends;
                    if (sub.hit)
                    begin
                        res_valid    = 1'b1;
                        res.item_id  = sub.item_id;
                        res.text     = text_buffer_reg;
                        res.text_len = text_count_reg;
                    end
                    else if (ends)
                    begin
                        res_valid   = 1'b1;
                        res.item_id = nmea_fx_pkg::ITEM_END;
                    end
                    field_pos_next   = 4'd0;
                    text_buffer_next = '0;
                    text_count_next  = 4'd0;
                    if (ends)
                        in_sentence_next = 1'b0;
                end
                else
                begin
                    field_pos_next = fp_inc;
                    if (sub.hit)
                    begin
                        text_buffer_next = buf_cap;
                        text_count_next  = cnt_cap;
                        if (fp_inc == sub.end_pos)
                        begin
                            // gga altitude unit closes the sentence when filled
                            ends = (kind == nmea_fx_pkg::KIND_GGA) &&
                                   (comma_count_reg == nmea_fx_pkg::FINAL_FIELD);
                            res_valid        = 1'b1;
                            res.item_id      = sub.item_id;
                            res.text         = buf_cap;
                            res.text_len     = cnt_cap;
                            res.last         = ends;
                            text_buffer_next = '0;
                            text_count_next  = 4'd0;
                            if (ends)
                                in_sentence_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg  <= 1'b0;
            header_pos_reg   <= 3'd0;
            kind_match_reg   <= 2'b11;
            sentence_pos_reg <= '0;
            comma_count_reg  <= 4'd0;
            field_pos_reg    <= 4'd0;
            text_buffer_reg  <= '0;
            text_count_reg   <= 4'd0;
        end
        else if (step)
        begin
            in_sentence_reg  <= in_sentence_next;
            header_pos_reg   <= header_pos_next;
            kind_match_reg   <= kind_match_next;
            sentence_pos_reg <= sentence_pos_next;
            comma_count_reg  <= comma_count_next;
            field_pos_reg    <= field_pos_next;
            text_buffer_reg  <= text_buffer_next;
            text_count_reg   <= text_count_next;
        end
    end

    // results only come from a sentence whose header has been matched
    a_res_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid |-> in_sentence_reg && header_pos_reg == nmea_fx_pkg::HDR_LEN)
        else $error("result outside a matched sentence body");

    // the final result of a sentence closes it
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && res.last && byte_in != nmea_fx_pkg::CHAR_DOLLAR
        |=> !in_sentence_reg)
        else $error("sentence still open after its final result");

    // the end marker carries no text and is always final
    a_end_item: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.item_id == nmea_fx_pkg::ITEM_END
        |-> res.last && res.text_len == 4'd0 && res.text == 64'd0)
        else $error("malformed end-of-sentence result");

    // no subfield buffers more than eight characters
    a_text_bound: assert property (@(posedge clk) disable iff (!rst_n)
        text_count_reg <= nmea_fx_pkg::TEXT_COUNT_MAX)
        else $error("text count beyond buffer size");

endmodule

// ----- hdl/nmea_fx_out_reg.sv -----
// result register with valid and stall toward the consumer
module nmea_fx_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  res_valid,
    input  nmea_fx_pkg::result_t  res,
    input  logic                  out_stall,
    output logic                  slot_free,
    output logic                  out_valid,
    output nmea_fx_pkg::result_t  out_res
);

    logic                  valid_reg;
    logic                  valid_next;
    nmea_fx_pkg::result_t  res_reg;
    logic                  load;

    assign slot_free  = !valid_reg || !out_stall;
    assign load       = slot_free && step && res_valid;
    assign valid_next = slot_free ? (step && res_valid) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule
